// ===== design/nhs_pkg.sv =====
// Shared types, constants and saturating helpers for the neo-Hookean stress kernel.
// No dependencies; every other file of the block imports this package.
package nhs_pkg;

    typedef logic signed [63:0] t_q64;

    localparam int DIM = 3;

    localparam t_q64 Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q64 Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam t_q64 Q_NMAX = 64'sh8000_0000_0000_0001;
    localparam t_q64 ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam t_q64 LN2_Q62 = 64'sh2C5C_85FD_F473_DE6B;

    // product shift amounts
    localparam logic [5:0] SH_Q32  = 6'd32;
    localparam logic [5:0] SH_HALF = 6'd33;
    localparam logic [5:0] SH_LN2  = 6'd62;

    // register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_LAMBDA = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MU     = 2'd1;

    // pipeline depths
    localparam int MUL_LAT = 2;
    localparam int DIV_LAT = 50;
    localparam int LN_LAT  = 73;
    localparam int T_JDET  = 7;
    localparam int LAT     = T_JDET + LN_LAT + 6;

    function automatic t_q64 sat_add(t_q64 a, t_q64 b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return t_q64'(s[63:0]);
    endfunction

    function automatic t_q64 sat_sub(t_q64 a, t_q64 b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return t_q64'(s[63:0]);
    endfunction

endpackage

// ===== design/neo_hookean_stress_energy.sv =====
// Neo-Hookean second Piola-Kirchhoff stress and strain energy, fully pipelined.
// A new displacement gradient is taken every cycle (o_busy stays low) and its
// result appears on o_done in start order; results cannot be held off. The
// depth is set by the log unit (normalize plus 32 squaring stages, each with a
// product and a result register) on the path from det F to the stress and
// energy outputs; the 96-step inverse divider runs in parallel with it. Lame
// constants are taken from the configuration port and must stay fixed while
// items are in flight. Uses nhs_pkg, nhs_mul, nhs_div, nhs_log.
module neo_hookean_stress_energy import nhs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_grad_00,
    input  logic signed [31:0] i_grad_01,
    input  logic signed [31:0] i_grad_02,
    input  logic signed [31:0] i_grad_10,
    input  logic signed [31:0] i_grad_11,
    input  logic signed [31:0] i_grad_12,
    input  logic signed [31:0] i_grad_20,
    input  logic signed [31:0] i_grad_21,
    input  logic signed [31:0] i_grad_22,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_IW-1:0]  i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [63:0] o_stress_00,
    output logic signed [63:0] o_stress_11,
    output logic signed [63:0] o_stress_22,
    output logic signed [63:0] o_stress_12,
    output logic signed [63:0] o_stress_02,
    output logic signed [63:0] o_stress_01,
    output logic signed [63:0] o_strain_energy,
    output logic               o_bad_volume
);

    localparam int T_LNJ = T_JDET + LN_LAT;
    localparam int T_INV = 10 + DIV_LAT;
    localparam int N_TD  = T_LNJ - 5;
    localparam int N_BAD = T_LNJ + 5 - T_JDET;
    localparam int N_INV = T_LNJ + 3 - T_INV;

    // C entry order: 00 11 22 12 02 01
    localparam int C_ROW [6] = '{0, 1, 2, 1, 0, 0};
    localparam int C_COL [6] = '{0, 1, 2, 2, 2, 1};
    // minor products of rows 1 and 2 of F
    localparam int JM_AC [6] = '{1, 2, 0, 2, 0, 1};
    localparam int JM_BC [6] = '{2, 1, 2, 0, 1, 0};
    // adjugate products as pairs of C entries
    localparam int AD_A [12] = '{1, 3, 0, 4, 0, 5, 4, 0, 5, 4, 4, 5};
    localparam int AD_B [12] = '{2, 3, 2, 4, 1, 5, 5, 3, 3, 1, 3, 2};
    // C entries 00 01 02 pair with adjugate 00 01 02
    localparam int DC_A [3] = '{0, 5, 4};

    logic [31:0]       r_lam;
    logic [31:0]       r_mu;
    t_q64              w_lam;
    t_q64              w_mu;
    logic [LAT-1:0]    r_vld;
    logic              w_acc;

    logic signed [31:0] w_g [3][3];
    t_q64 n_f   [3][3];
    t_q64 r_f   [3][3];
    t_q64 r_f0d [3][3];
    t_q64 w_cp  [6][3];
    t_q64 w_jm  [6];
    t_q64 r_c   [6];
    t_q64 r_jd  [3];
    t_q64 r_cd  [3][3];
    t_q64 w_jq  [3];
    t_q64 w_ap  [12];
    t_q64 n_tr;
    t_q64 r_t;
    t_q64 r_td  [N_TD];
    t_q64 r_jdet;
    t_q64 r_a   [6];
    t_q64 r_ad  [3][6];
    t_q64 w_dp  [3];
    t_q64 r_detc;
    t_q64 w_inv [6];
    t_q64 r_invd [N_INV][6];
    logic r_bad [N_BAD];
    t_q64 w_lnj;
    t_q64 w_ll;
    t_q64 w_sq;
    t_q64 r_inner;
    t_q64 w_em;
    t_q64 r_em_d;
    t_q64 w_el;
    t_q64 r_coef;
    t_q64 w_sp  [6];
    t_q64 r_w;
    t_q64 n_s   [6];
    t_q64 r_s   [6];
    t_q64 r_e;
    logic r_bv;

    function automatic t_q64 half_q(t_q64 t);
        logic [63:0] m;
        logic [63:0] h;
        m = t[63] ? 64'(-t) : 64'(t);
        h = m >> 1;
        return t[63] ? -t_q64'(h) : t_q64'(h);
    endfunction

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_start && !o_busy;
    assign w_lam       = t_q64'({16'd0, r_lam, 16'd0});
    assign w_mu        = t_q64'({16'd0, r_mu, 16'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam <= '0;
            r_mu  <= '0;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_LAMBDA: r_lam <= i_cfg_data;
                    REG_MU:     r_mu  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // F = I + 16 * grad
    always_comb begin
        w_g[0][0] = i_grad_00; w_g[0][1] = i_grad_01; w_g[0][2] = i_grad_02;
        w_g[1][0] = i_grad_10; w_g[1][1] = i_grad_11; w_g[1][2] = i_grad_12;
        w_g[2][0] = i_grad_20; w_g[2][1] = i_grad_21; w_g[2][2] = i_grad_22;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (DIM == 2 && (i == 2 || j == 2)) begin
                    n_f[i][j] = '0;
                end else begin
                    n_f[i][j] = t_q64'({{28{w_g[i][j][31]}}, w_g[i][j], 4'd0});
                end
                if (i == j) begin
                    n_f[i][j] = n_f[i][j] + ONE_Q32;
                end
            end
        end
    end

    // C = F^T F and the 2x2 minors of F
    for (genvar e = 0; e < 6; e++) begin : g_ce
        for (genvar k = 0; k < 3; k++) begin : g_ck
            nhs_mul u_mul_c (
                .i_clk (i_clk),
                .i_a   (r_f[k][C_ROW[e]]),
                .i_b   (r_f[k][C_COL[e]]),
                .i_sh  (SH_Q32),
                .o_p   (w_cp[e][k])
            );
        end
    end

    for (genvar p = 0; p < 6; p++) begin : g_jm
        nhs_mul u_mul_jm (
            .i_clk (i_clk),
            .i_a   (r_f[1][JM_AC[p]]),
            .i_b   (r_f[2][JM_BC[p]]),
            .i_sh  (SH_Q32),
            .o_p   (w_jm[p])
        );
    end

    // det F from row 0 and the minors; adjugate of C
    for (genvar d = 0; d < 3; d++) begin : g_jq
        nhs_mul u_mul_jq (
            .i_clk (i_clk),
            .i_a   (r_f0d[2][d]),
            .i_b   (r_jd[d]),
            .i_sh  (SH_Q32),
            .o_p   (w_jq[d])
        );
    end

    for (genvar p = 0; p < 12; p++) begin : g_ap
        nhs_mul u_mul_ap (
            .i_clk (i_clk),
            .i_a   (r_c[AD_A[p]]),
            .i_b   (r_c[AD_B[p]]),
            .i_sh  (SH_Q32),
            .o_p   (w_ap[p])
        );
    end

    for (genvar d = 0; d < 3; d++) begin : g_dc
        nhs_mul u_mul_dc (
            .i_clk (i_clk),
            .i_a   (r_cd[2][d]),
            .i_b   (r_a[DC_A[d]]),
            .i_sh  (SH_Q32),
            .o_p   (w_dp[d])
        );
    end

    // inverse of C, one divider per unique entry
    for (genvar k = 0; k < 6; k++) begin : g_div
        nhs_div u_div (
            .i_clk (i_clk),
            .i_num (r_ad[2][k]),
            .i_den (r_detc),
            .o_q   (w_inv[k])
        );
    end

    nhs_log u_log (
        .i_clk (i_clk),
        .i_j   (r_jdet),
        .o_ln  (w_lnj)
    );

    nhs_mul u_mul_lam_ln (
        .i_clk (i_clk),
        .i_a   (w_lam),
        .i_b   (w_lnj),
        .i_sh  (SH_Q32),
        .o_p   (w_ll)
    );

    nhs_mul u_mul_ln_sq (
        .i_clk (i_clk),
        .i_a   (w_lnj),
        .i_b   (w_lnj),
        .i_sh  (SH_Q32),
        .o_p   (w_sq)
    );

    nhs_mul u_mul_mu_in (
        .i_clk (i_clk),
        .i_a   (w_mu),
        .i_b   (r_inner),
        .i_sh  (SH_Q32),
        .o_p   (w_em)
    );

    nhs_mul u_mul_lam_sq (
        .i_clk (i_clk),
        .i_a   (w_lam),
        .i_b   (w_sq),
        .i_sh  (SH_HALF),
        .o_p   (w_el)
    );

    for (genvar k = 0; k < 6; k++) begin : g_sp
        nhs_mul u_mul_sp (
            .i_clk (i_clk),
            .i_a   (r_coef),
            .i_b   (r_invd[N_INV-1][k]),
            .i_sh  (SH_Q32),
            .o_p   (w_sp[k])
        );
    end

    always_comb begin
        n_tr = '0;
        for (int i = 0; i < DIM; i++) begin
            n_tr = sat_add(n_tr, r_c[i]);
        end
        n_tr = sat_sub(n_tr, t_q64'(64'(DIM) << 32));
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_s[k] = w_sp[k];
            if (k < 3) begin
                n_s[k] = sat_add(n_s[k], w_mu);
            end
            if ((DIM == 2 && k >= 2 && k <= 4) || r_bad[N_BAD-1]) begin
                n_s[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        for (int j = 0; j < 3; j++) begin
            r_f0d[0][j] <= r_f[0][j];
        end
        r_f0d[1] <= r_f0d[0];
        r_f0d[2] <= r_f0d[1];

        for (int e = 0; e < 6; e++) begin
            r_c[e] <= sat_add(sat_add(w_cp[e][0], w_cp[e][1]), w_cp[e][2]);
        end
        for (int d = 0; d < 3; d++) begin
            r_jd[d] <= sat_sub(w_jm[2*d], w_jm[2*d+1]);
        end

        r_cd[0] <= '{r_c[0], r_c[5], r_c[4]};
        r_cd[1] <= r_cd[0];
        r_cd[2] <= r_cd[1];

        r_t     <= n_tr;
        r_td[0] <= r_t;
        for (int i = 1; i < N_TD; i++) begin
            r_td[i] <= r_td[i-1];
        end

        r_jdet <= sat_add(sat_sub(w_jq[0], w_jq[1]), w_jq[2]);
        for (int k = 0; k < 6; k++) begin
            r_a[k] <= sat_sub(w_ap[2*k], w_ap[2*k+1]);
        end
        r_ad[0] <= r_a;
        r_ad[1] <= r_ad[0];
        r_ad[2] <= r_ad[1];

        r_detc <= sat_add(sat_add(w_dp[0], w_dp[1]), w_dp[2]);

        r_invd[0] <= w_inv;
        for (int i = 1; i < N_INV; i++) begin
            r_invd[i] <= r_invd[i-1];
        end

        // flag non-positive volume
        r_bad[0] <= r_jdet[63] || (r_jdet == '0);
        for (int i = 1; i < N_BAD; i++) begin
            r_bad[i] <= r_bad[i-1];
        end

        r_inner <= sat_add(sat_sub('0, w_lnj), half_q(r_td[N_TD-1]));
        r_coef  <= sat_sub(w_ll, w_mu);
        r_em_d  <= w_em;
        r_w     <= sat_add(w_el, r_em_d);

        r_s  <= n_s;
        r_e  <= r_bad[N_BAD-1] ? t_q64'(0) : r_w;
        r_bv <= r_bad[N_BAD-1] && r_vld[LAT-2];
    end

    assign o_done          = r_vld[LAT-1];
    assign o_stress_00     = r_s[0];
    assign o_stress_11     = r_s[1];
    assign o_stress_22     = r_s[2];
    assign o_stress_12     = r_s[3];
    assign o_stress_02     = r_s[4];
    assign o_stress_01     = r_s[5];
    assign o_strain_energy = r_e;
    assign o_bad_volume    = r_bv;

endmodule

// ===== design/nhs_mul.sv =====
// Two-stage signed 64x64 fractional multiplier: four 32x32 partial products,
// then a 128-bit sum, right shift, truncation toward zero and saturation. Uses nhs_pkg.
module nhs_mul import nhs_pkg::*; (
    input  logic       i_clk,
    input  t_q64       i_a,
    input  t_q64       i_b,
    input  logic [5:0] i_sh,
    output t_q64       o_p
);

    logic [63:0]  w_ua;
    logic [63:0]  w_ub;
    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic         r_neg;
    logic [5:0]   r_sh;
    logic [127:0] w_full;
    logic [127:0] w_shr;
    t_q64         n_p;
    t_q64         r_p;

    assign w_ua = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign w_ub = i_b[63] ? 64'(-i_b) : 64'(i_b);

    always_ff @(posedge i_clk) begin
        r_ll  <= w_ua[31:0]  * w_ub[31:0];
        r_lh  <= w_ua[31:0]  * w_ub[63:32];
        r_hl  <= w_ua[63:32] * w_ub[31:0];
        r_hh  <= w_ua[63:32] * w_ub[63:32];
        r_neg <= i_a[63] ^ i_b[63];
        r_sh  <= i_sh;
    end

    assign w_full = {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
                  + {r_hh, 64'd0};
    assign w_shr  = w_full >> r_sh;

    always_comb begin
        if (|w_shr[127:63]) begin
            n_p = r_neg ? Q_NMAX : Q_MAX;
        end else if (r_neg) begin
            n_p = -t_q64'({1'b0, w_shr[62:0]});
        end else begin
            n_p = t_q64'({1'b0, w_shr[62:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== design/nhs_div.sv =====
// Pipelined restoring divider: trunc(num * 2^32 / den), saturating, two quotient
// bits per stage over 96 steps. Uses nhs_pkg.
module nhs_div import nhs_pkg::*; (
    input  logic i_clk,
    input  t_q64 i_num,
    input  t_q64 i_den,
    output t_q64 o_q
);

    localparam int NSTG = 48;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvd;
        logic [63:0] ud;
        logic        ovf;
        logic        neg;
        logic        dz;
        logic        npos;
        logic        nneg;
    } t_dv;

    function automatic t_dv dstep(t_dv x);
        logic [64:0] t;
        t_dv y;
        y = x;
        t = {x.rem, x.dvd[63]};
        y.dvd = {x.dvd[62:0], 1'b0};
        y.ovf = x.ovf | x.quo[63];
        if (t >= {1'b0, x.ud}) begin
            y.rem = 64'(t - {1'b0, x.ud});
            y.quo = {x.quo[62:0], 1'b1};
        end else begin
            y.rem = t[63:0];
            y.quo = {x.quo[62:0], 1'b0};
        end
        return y;
    endfunction

    t_dv  r_st [NSTG+1];
    t_dv  n_st0;
    t_dv  w_last;
    t_q64 n_q;
    t_q64 r_q;

    always_comb begin
        n_st0      = '0;
        n_st0.dvd  = i_num[63] ? 64'(-i_num) : 64'(i_num);
        n_st0.ud   = i_den[63] ? 64'(-i_den) : 64'(i_den);
        n_st0.neg  = i_num[63] ^ i_den[63];
        n_st0.dz   = (i_den == '0);
        n_st0.nneg = i_num[63];
        n_st0.npos = !i_num[63] && (i_num != '0);
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
        for (int s = 1; s <= NSTG; s++) begin
            r_st[s] <= dstep(dstep(r_st[s-1]));
        end
    end

    assign w_last = r_st[NSTG];

    always_comb begin
        if (w_last.dz) begin
            n_q = w_last.npos ? Q_MAX : (w_last.nneg ? Q_NMAX : t_q64'(0));
        end else if (w_last.ovf || w_last.quo[63]) begin
            n_q = w_last.neg ? Q_NMAX : Q_MAX;
        end else if (w_last.neg) begin
            n_q = -t_q64'(w_last.quo);
        end else begin
            n_q = t_q64'(w_last.quo);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== design/nhs_log.sv =====
// Pipelined natural log of a positive Q31.32 value: leading-zero normalizer,
// 32 square-and-compare stages for log2 fraction bits, then scaling by ln 2. Uses nhs_pkg, nhs_mul.
module nhs_log import nhs_pkg::*; (
    input  logic i_clk,
    input  t_q64 i_j,
    output t_q64 o_ln
);

    localparam int NIT = 32;

    typedef struct packed {
        logic [63:0] pll;
        logic [61:0] plh;
        logic [59:0] phh;
        logic [31:0] f;
        logic [5:0]  lz;
    } t_la;

    typedef struct packed {
        logic [61:0] m;
        logic [31:0] f;
        logic [5:0]  lz;
    } t_lb;

    logic [62:0] r_nx [7];
    logic [5:0]  r_lz [7];
    t_lb         w_in [NIT];
    t_la         r_a  [NIT];
    t_lb         n_b  [NIT];
    t_lb         r_b  [NIT];
    logic [6:0]  w_e;
    t_q64        w_l2;

    // normalize so the leading one lands in bit 62
    always_ff @(posedge i_clk) begin
        r_nx[0] <= i_j[62:0];
        r_lz[0] <= '0;
        for (int s = 1; s <= 6; s++) begin
            if ((r_nx[s-1] >> (63 - (32 >> (s - 1)))) == 63'd0) begin
                r_nx[s] <= r_nx[s-1] << (32 >> (s - 1));
                r_lz[s] <= r_lz[s-1] + 6'(32 >> (s - 1));
            end else begin
                r_nx[s] <= r_nx[s-1];
                r_lz[s] <= r_lz[s-1];
            end
        end
    end

    always_comb begin
        w_in[0] = '{m: r_nx[6][62:1], f: 32'd0, lz: r_lz[6]};
        for (int i = 1; i < NIT; i++) begin
            w_in[i] = r_b[i-1];
        end
    end

    always_comb begin
        logic [123:0] sq;
        logic [62:0]  s;
        for (int i = 0; i < NIT; i++) begin
            sq = 124'(r_a[i].pll) + (124'(r_a[i].plh) << 33) + (124'(r_a[i].phh) << 64);
            s  = sq[123:61];
            n_b[i].lz = r_a[i].lz;
            if (s[62]) begin
                n_b[i].m = s[62:1];
                n_b[i].f = {r_a[i].f[30:0], 1'b1};
            end else begin
                n_b[i].m = s[61:0];
                n_b[i].f = {r_a[i].f[30:0], 1'b0};
            end
        end
    end

    // square of m: low*low, low*high, high*high
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NIT; i++) begin
            r_a[i].pll <= w_in[i].m[31:0]  * w_in[i].m[31:0];
            r_a[i].plh <= w_in[i].m[31:0]  * w_in[i].m[61:32];
            r_a[i].phh <= w_in[i].m[61:32] * w_in[i].m[61:32];
            r_a[i].f   <= w_in[i].f;
            r_a[i].lz  <= w_in[i].lz;
            r_b[i]     <= n_b[i];
        end
    end

    // integer part of log2 is 30 minus the leading zero count
    assign w_e  = 7'd30 - {1'b0, r_b[NIT-1].lz};
    assign w_l2 = t_q64'({{25{w_e[6]}}, w_e, r_b[NIT-1].f});

    nhs_mul u_mul_ln2 (
        .i_clk (i_clk),
        .i_a   (w_l2),
        .i_b   (LN2_Q62),
        .i_sh  (SH_LN2),
        .o_p   (o_ln)
    );

endmodule

// ===== design/nhs_chk.sv =====
// Port-level checks for the neo-Hookean stress kernel, bound to the top level.
// Uses nhs_pkg for the pipeline depth.
module nhs_chk import nhs_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic signed [63:0] o_stress_00,
    input logic signed [63:0] o_stress_11,
    input logic signed [63:0] o_stress_22,
    input logic signed [63:0] o_stress_12,
    input logic signed [63:0] o_stress_02,
    input logic signed [63:0] o_stress_01,
    input logic signed [63:0] o_strain_energy,
    input logic               o_bad_volume
);

    // every result comes from a start transfer a fixed depth earlier
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without matching start transfer");

    // no start transfer is lost
    a_start_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("start transfer produced no result");

    // bad volume comes with a result whose values are all zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bad_volume |-> o_done && o_stress_00 == 0 && o_stress_11 == 0
            && o_stress_22 == 0 && o_stress_12 == 0 && o_stress_02 == 0
            && o_stress_01 == 0 && o_strain_energy == 0)
        else $error("bad volume with nonzero outputs");

endmodule

bind neo_hookean_stress_energy nhs_chk u_nhs_chk (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for neo_hookean_stress_energy: drives displacement gradients
// and Lame constants, predicts stress and energy per item and compares each result.
// Depends on nhs_pkg and the neo_hookean_stress_energy RTL.
`timescale 1ns / 100ps

module tb;
    import nhs_pkg::*;

    localparam logic [CFG_IW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IW-1:0] REG_SPARE_3 = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam logic signed [31:0] G_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] G_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] G_NEG_ONE = -32'sd268435456;   // F diagonal becomes zero

    typedef struct {
        t_q64 s00, s11, s22, s12, s02, s01, energy;
        logic bad;
    } stress_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic signed [31:0] grad [9];
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_done;
    t_q64 o_stress_00, o_stress_11, o_stress_22, o_stress_12, o_stress_02, o_stress_01;
    t_q64 o_strain_energy;
    logic o_bad_volume;

    logic [31:0] lambda_q, mu_q;
    stress_t pending_results[$];
    int errors = 0;
    int stall_cycles = 0;
    bit idling_on = 1'b1;

    initial begin
        for (int k = 0; k < 9; k++) begin
            grad[k] = '0;
        end
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    neo_hookean_stress_energy dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_grad_00(grad[0]), .i_grad_01(grad[1]), .i_grad_02(grad[2]),
        .i_grad_10(grad[3]), .i_grad_11(grad[4]), .i_grad_12(grad[5]),
        .i_grad_20(grad[6]), .i_grad_21(grad[7]), .i_grad_22(grad[8]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_stress_00(o_stress_00), .o_stress_11(o_stress_11), .o_stress_22(o_stress_22),
        .o_stress_12(o_stress_12), .o_stress_02(o_stress_02), .o_stress_01(o_stress_01),
        .o_strain_energy(o_strain_energy), .o_bad_volume(o_bad_volume)
    );

    // ---------------- fixed-point arithmetic of the kernel ----------------

    function automatic t_q64 from_mag(logic neg, logic [127:0] m);
        if (m > 128'h7FFF_FFFF_FFFF_FFFF) begin
            return neg ? Q_NMAX : Q_MAX;
        end
        return neg ? -t_q64'(m[63:0]) : t_q64'(m[63:0]);
    endfunction

    function automatic logic [63:0] mag(t_q64 a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_q64 qmul(t_q64 a, t_q64 b, int sh);
        logic [127:0] p;
        p = {64'b0, mag(a)} * {64'b0, mag(b)};
        p = p >> sh;
        return from_mag(a[63] ^ b[63], p);
    endfunction

    function automatic t_q64 qadd(t_q64 a, t_q64 b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic t_q64 qsub(t_q64 a, t_q64 b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic t_q64 cross_diff(t_q64 a, t_q64 b, t_q64 c, t_q64 d);
        return qsub(qmul(a, b, 32), qmul(c, d, 32));
    endfunction

    function automatic t_q64 qdiv(t_q64 num, t_q64 den);
        logic [127:0] q;
        if (den == 0) begin
            return num > 0 ? Q_MAX : (num < 0 ? Q_NMAX : t_q64'(0));
        end
        q = {32'b0, mag(num), 32'b0} / {64'b0, mag(den)};
        return from_mag(num[63] ^ den[63], q);
    endfunction

    // natural log of a positive Q.32 value: normalize, then 32 squaring steps
    function automatic t_q64 qln(t_q64 j);
        logic [63:0] m, frac;
        int p;
        longint l2;
        p = 62;
        while (p > 0 && j[p] == 1'b0) p--;
        m = (p <= 61) ? (j << (61 - p)) : (j >> (p - 61));
        frac = '0;
        for (int k = 0; k < 32; k++) begin
            m = qmul(m, m, 61);
            frac = frac << 1;
            if (m >= (64'd2 << 61)) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        l2 = (longint'(p) - 32) * 64'sd4294967296 + longint'(frac);
        return qmul(l2, LN2_Q62, 62);
    endfunction

    function automatic stress_t predict_stress(logic signed [31:0] g [9]);
        t_q64 f [3][3];
        t_q64 c [3][3];
        t_q64 jdet, a00, a11, a22, a01, a02, a12, detc, lam, mu, lnj, coef, tr, tw, inner;
        t_q64 inv [6];
        t_q64 s [6];
        t_q64 acc;
        stress_t r;
        bit two;
        two = (DIM == 2);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                f[i][j] = (two && (i == 2 || j == 2)) ? t_q64'(0) : t_q64'(g[i*3+j]) * 16;
                if (i == j) f[i][j] = f[i][j] + ONE_Q32;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc = qadd(acc, qmul(f[k][i], f[k][j], 32));
                c[i][j] = acc;
            end
        end
        jdet = qadd(qsub(qmul(f[0][0], cross_diff(f[1][1], f[2][2], f[1][2], f[2][1]), 32),
                         qmul(f[0][1], cross_diff(f[1][0], f[2][2], f[1][2], f[2][0]), 32)),
                    qmul(f[0][2], cross_diff(f[1][0], f[2][1], f[1][1], f[2][0]), 32));
        r = '{default: '0};
        if (jdet <= 0) begin
            r.bad = 1'b1;
            return r;
        end
        a00 = cross_diff(c[1][1], c[2][2], c[1][2], c[2][1]);
        a11 = cross_diff(c[0][0], c[2][2], c[0][2], c[2][0]);
        a22 = cross_diff(c[0][0], c[1][1], c[0][1], c[1][0]);
        a01 = cross_diff(c[0][2], c[2][1], c[0][1], c[2][2]);
        a02 = cross_diff(c[0][1], c[1][2], c[0][2], c[1][1]);
        a12 = cross_diff(c[0][2], c[1][0], c[0][0], c[1][2]);
        detc = qadd(qadd(qmul(c[0][0], a00, 32), qmul(c[0][1], a01, 32)),
                    qmul(c[0][2], a02, 32));
        inv[0] = qdiv(a00, detc);
        inv[1] = qdiv(a11, detc);
        inv[2] = qdiv(a22, detc);
        inv[3] = qdiv(a12, detc);
        inv[4] = qdiv(a02, detc);
        inv[5] = qdiv(a01, detc);
        lam = t_q64'({32'b0, lambda_q}) <<< 16;
        mu = t_q64'({32'b0, mu_q}) <<< 16;
        lnj = qln(jdet);
        coef = qsub(qmul(lam, lnj, 32), mu);
        for (int k = 0; k < 6; k++) begin
            s[k] = qmul(coef, inv[k], 32);
            if (k < 3) s[k] = qadd(s[k], mu);
        end
        if (two) begin
            s[2] = 0;
            s[3] = 0;
            s[4] = 0;
        end
        tr = 0;
        for (int i = 0; i < (two ? 2 : 3); i++) tr = qadd(tr, c[i][i]);
        tw = qsub(tr, (two ? 2 : 3) * ONE_Q32);
        inner = qadd(qsub(0, lnj), qmul(tw, 1, 1));
        r.energy = qadd(qmul(lam, qmul(lnj, lnj, 32), 33), qmul(mu, inner, 32));
        r.s00 = s[0];
        r.s11 = s[1];
        r.s22 = s[2];
        r.s12 = s[3];
        r.s02 = s[4];
        r.s01 = s[5];
        return r;
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(string name, t_q64 exp_v, t_q64 act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        stress_t e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("stress_00", e.s00, o_stress_00);
                check_field("stress_11", e.s11, o_stress_11);
                check_field("stress_22", e.s22, o_stress_22);
                check_field("stress_12", e.s12, o_stress_12);
                check_field("stress_02", e.s02, o_stress_02);
                check_field("stress_01", e.s01, o_stress_01);
                check_field("strain_energy", e.energy, o_strain_energy);
                check_field("bad_volume", t_q64'(e.bad), t_q64'(o_bad_volume));
            end
        end
    end

    // hang detection: count cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_gradient(logic signed [31:0] g [9]);
        @(negedge i_clk);
        i_start <= 1'b1;
        for (int k = 0; k < 9; k++) grad[k] <= g[k];
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_stress(g));
    endtask

    task automatic maybe_idle();
        int n;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_LAMBDA) lambda_q = val;
        else if (idx == REG_MU) mu_q = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_grad_entry();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        if (sel < 8) return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
        return $urandom;
    endfunction

    task automatic send_random_items(int count);
        logic signed [31:0] g [9];
        repeat (count) begin
            for (int k = 0; k < 9; k++) g[k] = rand_grad_entry();
            send_gradient(g);
            maybe_idle();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        logic signed [31:0] g [9];
        drain();
        write_reg(REG_LAMBDA, 32'h0001_0000);
        write_reg(REG_MU, 32'h0000_8000);
        g = '{default: 0};
        send_gradient(g);                        // undeformed
        g = '{default: G_MAX};
        send_gradient(g);
        g = '{default: G_MIN};
        send_gradient(g);
        g = '{default: 0};
        g[0] = G_NEG_ONE * 2;                    // inverted volume
        send_gradient(g);
        g[0] = G_NEG_ONE;                        // zero volume
        send_gradient(g);
        g[0] = G_NEG_ONE + 32'sd2048;            // tiny positive volume, singular C
        send_gradient(g);
        for (int k = 0; k < 9; k++) begin        // one field at a time, at max or min
            g = '{default: 0};
            g[k] = (k % 2) ? G_MIN : G_MAX;
            send_gradient(g);
            maybe_idle();
        end
        g = '{default: 0};
        g[1] = 32'sh0800_0000;                   // simple shear
        send_gradient(g);
        g = '{default: 32'sh0100_0000};
        send_gradient(g);
    endtask

    task automatic test_config_settings();
        logic [31:0] lam_set [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0003_0000, 32'h0};
        logic [31:0] mu_set [4]  = '{32'h0, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0};
        lam_set[3] = $urandom;
        mu_set[3] = $urandom;
        for (int s = 0; s < 4; s++) begin
            drain();
            write_reg(REG_LAMBDA, lam_set[s]);
            write_reg(REG_MU, mu_set[s]);
            send_random_items(60);
        end
    endtask

    task automatic test_unused_index();
        drain();
        write_reg(REG_LAMBDA, 32'h0002_0000);
        write_reg(REG_MU, 32'h0001_0000);
        write_reg(REG_SPARE_2, $urandom);
        write_reg(REG_SPARE_3, $urandom);
        send_random_items(20);
    endtask

    task automatic test_random_with_pause();
        drain();
        write_reg(REG_LAMBDA, $urandom_range(0, 32'h0010_0000));
        write_reg(REG_MU, $urandom_range(0, 32'h0010_0000));
        send_random_items(70);
        // hold the sender until the pipeline is empty, then resume
        drain();
        send_random_items(70);
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        send_random_items(150);
    endtask

    initial begin
        lambda_q = '0;
        mu_q = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_settings();
        test_unused_index();
        test_random_with_pause();
        test_back_to_back();
        drain();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/nhs_pkg.sv
design/nhs_mul.sv
design/nhs_div.sv
design/nhs_log.sv
design/neo_hookean_stress_energy.sv
design/nhs_chk.sv
tb/sv/tb.sv
